// ===== rtl/core/fys_pkg.sv =====
// Package for the shuffle unit: shared types and constants.
// No dependencies.
`default_nettype none
package fys_pkg;
    localparam int unsigned DATA_W = 32;

    // Entry of the queue between the front end and the shuffle engine.
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] random_word;
        logic              last;
    } t_item;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_DIV,
        ST_RD,
        ST_DIV_GO,
        ST_SWAP,
        ST_EMIT_RD,
        ST_EMIT
    } t_state;
endpackage
`default_nettype wire

// ===== rtl/core/fisher_yates_shuffle_unit.sv =====
// Top level of the shuffle unit: front queue feeding the shuffle engine.
// Depends on fys_pkg, fys_front, fys_engine.
// Loading: one transaction per cycle while full is low. Each swap step runs a store read,
// a divider start, the bit-serial remainder unit and a swap write, in that order.
// Results of an N-element list are emitted after the last item is accepted and shuffled.
// Reset: synchronous, active low, clears all control state.
`default_nettype none
module fisher_yates_shuffle_unit #(
    parameter int MAX_ITEMS = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         push,
    output logic        full,
    input  wire [31:0]  i_value,
    input  wire [31:0]  i_random_word,
    input  wire         i_last,
    output logic        empty,
    input  wire         pop,
    output logic [31:0] o_value_res,
    output logic        o_last_res,
    output logic        o_overflow
);
    fys_pkg::t_item w_in, w_q;
    logic w_vld, w_take;

    // Pack the input fields into one queue entry.
    assign w_in = '{value: i_value, random_word: i_random_word, last: i_last};

    // Front end: hold up to two transactions while the engine is busy shuffling
    // or emitting; full stalls the producer.
    fys_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_item(w_in),
        .o_full(full), .o_valid(w_vld), .o_item(w_q), .i_take(w_take)
    );

    // Back end: store the list, shuffle on the last item, then emit the list
    // through a one-entry result register that holds until popped.
    fys_engine #(.MAX_ITEMS(MAX_ITEMS)) u_eng (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_vld), .i_item(w_q),
        .o_take(w_take), .o_empty(empty), .i_pop(pop),
        .o_value_res(o_value_res), .o_last_res(o_last_res), .o_overflow(o_overflow)
    );
endmodule
`default_nettype wire

// ===== rtl/core/fys_front.sv =====
// Input front end: two-entry queue that decouples the input from the engine.
// Depends on fys_pkg.
`default_nettype none
module fys_front (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_push,
    input  fys_pkg::t_item i_item,
    output logic          o_full,
    output logic          o_valid,
    output fys_pkg::t_item o_item,
    input  wire           i_take
);
    fys_pkg::t_item r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd, r_wr;
    logic       w_push, w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wr] <= i_item;
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (w_push) r_wr <= !r_wr;
            if (w_pop)  r_rd <= !r_rd;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/fys_divider.sv =====
// Iterative 32-bit remainder unit, one quotient bit per cycle.
// Depends on fys_pkg.
`default_nettype none
module fys_divider (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    input  wire [fys_pkg::DATA_W-1:0]  i_dividend,
    input  wire [6:0]                  i_divisor,
    output logic                       o_done,
    output logic [6:0]                 o_rem
);
    logic [fys_pkg::DATA_W-1:0] r_num;
    logic [7:0] r_rem;
    logic [6:0] r_div;
    logic [5:0] r_cnt;
    logic       r_busy;
    logic [7:0] w_sh;

    assign w_sh   = {r_rem[6:0], r_num[fys_pkg::DATA_W-1]};
    assign o_rem  = r_rem[6:0];
    assign o_done = r_busy && (r_cnt == 6'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'(fys_pkg::DATA_W);
            r_num  <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            if (r_cnt == 6'd0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 6'd1;
                r_num <= {r_num[fys_pkg::DATA_W-2:0], 1'b0};
                // restore step
                r_rem <= (w_sh >= {1'b0, r_div}) ? w_sh - {1'b0, r_div} : w_sh;
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/fys_engine.sv =====
// Shuffle engine: stores the list, runs the swap steps and emits the result.
// Depends on fys_pkg and fys_divider.
`default_nettype none
module fys_engine #(
    parameter int MAX_ITEMS = 64
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_valid,
    input  fys_pkg::t_item            i_item,
    output logic                      o_take,
    output logic                      o_empty,
    input  wire                       i_pop,
    output logic [fys_pkg::DATA_W-1:0] o_value_res,
    output logic                      o_last_res,
    output logic                      o_overflow
);
    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);

    logic [fys_pkg::DATA_W-1:0] r_elem [MAX_ITEMS];
    logic [fys_pkg::DATA_W-1:0] r_rand [MAX_ITEMS];

    fys_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_cnt;
    logic          r_drop;
    logic [AW-1:0] r_i, r_k, r_j;
    logic [fys_pkg::DATA_W-1:0] r_a, r_b, r_rw;
    logic [fys_pkg::DATA_W-1:0] r_out;
    logic          r_out_last, r_out_ovf, r_out_vld;
    logic          w_start, w_done;
    logic [6:0]    w_rem;
    logic          w_acc, w_room, w_emit_last;

    fys_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_dividend(r_rw), .i_divisor(7'(r_i) + 7'd1),
        .o_done(w_done), .o_rem(w_rem)
    );

    assign o_take      = (r_state == fys_pkg::ST_LOAD);
    assign o_empty     = !r_out_vld;
    assign o_value_res = r_out;
    assign o_last_res  = r_out_last;
    assign o_overflow  = r_out_ovf;

    assign w_acc       = o_take && i_valid;
    assign w_room      = (r_cnt < CW'(MAX_ITEMS));
    assign w_emit_last = ((CW'(r_k) + CW'(1)) == r_cnt);

    always_comb begin
        n_state = r_state;
        w_start = 1'b0;
        unique case (r_state)
            fys_pkg::ST_LOAD: begin
                if (w_acc && i_item.last) begin
                    // count after this item lands
                    if ((r_cnt + CW'(w_room)) < CW'(2)) n_state = fys_pkg::ST_EMIT_RD;
                    else                               n_state = fys_pkg::ST_RD;
                end
            end
            fys_pkg::ST_RD:    n_state = fys_pkg::ST_DIV_GO;
            // random word is registered now; start the divider on it
            fys_pkg::ST_DIV_GO: begin n_state = fys_pkg::ST_DIV; w_start = 1'b1; end
            fys_pkg::ST_DIV:  if (w_done) n_state = fys_pkg::ST_SWAP;
            fys_pkg::ST_SWAP: n_state = (r_i == AW'(1)) ? fys_pkg::ST_EMIT_RD : fys_pkg::ST_RD;
            fys_pkg::ST_EMIT_RD: if (!r_out_vld || i_pop) n_state = fys_pkg::ST_EMIT;
            fys_pkg::ST_EMIT: n_state = w_emit_last ? fys_pkg::ST_LOAD : fys_pkg::ST_EMIT_RD;
            default: n_state = fys_pkg::ST_LOAD;
        endcase
    end

    // Memory accesses: read and write in clocked logic.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            fys_pkg::ST_LOAD: if (w_acc && w_room) begin
                r_elem[r_cnt[AW-1:0]] <= i_item.value;
                r_rand[r_cnt[AW-1:0]] <= i_item.random_word;
            end
            fys_pkg::ST_RD: begin
                r_rw <= r_rand[r_k];
                r_a  <= r_elem[r_i];
            end
            fys_pkg::ST_DIV: if (w_done) begin
                r_j <= w_rem[AW-1:0];
                r_b <= r_elem[w_rem[AW-1:0]];
            end
            fys_pkg::ST_SWAP: begin
                r_elem[r_j] <= r_a;
                if (r_j != r_i) r_elem[r_i] <= r_b;
            end
            fys_pkg::ST_EMIT_RD: r_b <= r_elem[r_k];
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= fys_pkg::ST_LOAD;
            r_cnt     <= '0;
            r_drop    <= 1'b0;
            r_i       <= '0;
            r_k       <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == fys_pkg::ST_EMIT) r_out_vld <= 1'b1;
            else if (i_pop && r_out_vld)     r_out_vld <= 1'b0;
            unique case (r_state)
                fys_pkg::ST_LOAD: if (w_acc) begin
                    if (w_room) r_cnt <= r_cnt + CW'(1);
                    else        r_drop <= 1'b1;
                    r_i <= AW'(r_cnt + CW'(w_room) - CW'(1));
                    r_k <= '0;
                end
                fys_pkg::ST_SWAP: begin
                    r_i <= r_i - AW'(1);
                    r_k <= (r_i == AW'(1)) ? '0 : r_k + AW'(1);
                end
                fys_pkg::ST_EMIT: begin
                    r_out      <= r_b;
                    r_out_last <= w_emit_last;
                    r_out_ovf  <= r_drop;
                    if (w_emit_last) begin
                        // list done: clear for the next one
                        r_cnt  <= '0;
                        r_drop <= 1'b0;
                        r_k    <= '0;
                    end else begin
                        r_k <= r_k + AW'(1);
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/fys_checker.sv =====
// Port checker for the shuffle unit, bound to the top level.
// Depends on fisher_yates_shuffle_unit ports only.
`default_nettype none
module fys_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        empty,
    input wire        pop,
    input wire [31:0] o_value_res,
    input wire        o_last_res,
    input wire        o_overflow
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_value_res))) else $error("result changed");
    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_last_res) |=> (empty || $stable(o_overflow)))
        else $error("overflow changed within list");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> empty) else $error("not empty");
endmodule
bind fisher_yates_shuffle_unit fys_checker u_chk (.*);
`default_nettype wire
